[src/gte_pkg.sv]
// ----------------------------------------------------------------------------
// gte_pkg
// Shared codes and default sizes for the graph traversal engine.
// ----------------------------------------------------------------------------
package gte_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_DEGREE_DEF   = 8;

    // fixed field widths
    localparam int VTX_W = 5;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int CNT_W = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BFS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DFS  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

[src/graph_traversal_engine_top.sv]
// ----------------------------------------------------------------------------
// graph_traversal_engine_top
// Undirected graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  command  | cmd, first_vertex, second_vertex          | start & !busy
//  result   | visited_vertex, status, last              | result_valid, 1 cycle
//  config   | cfg_wr_data (vertex_count)                | cfg_wr_en
//
//  busy in dispatch, edge, edge2 for a stored edge; dispatch, edge for a full
//  list; dispatch for a range error or unknown command. breadth-first: pop,
//  vertex, check per vertex, then check, neighbour per entry; depth-first:
//  check, pop per vertex, then check, neighbour per entry. the final result
//  shows in the first idle cycle. reset clears degrees, visited marks and
//  control; no clearing pass. the receiver cannot stall: one-cycle results.
module graph_traversal_engine_top #(
    parameter int MAX_VERTICES = gte_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gte_pkg::MAX_DEGREE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gte_pkg::CMD_W-1:0]   cmd,
    input  logic [gte_pkg::VTX_W-1:0]   first_vertex,
    input  logic [gte_pkg::VTX_W-1:0]   second_vertex,
    input  logic                        cfg_wr_en,
    input  logic [gte_pkg::CNT_W-1:0]   cfg_wr_data,
    output logic                        result_valid,
    output logic [gte_pkg::VTX_W-1:0]   visited_vertex,
    output logic [gte_pkg::ST_W-1:0]    status,
    output logic                        last
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int TW = VW + 1;
    localparam int NW = 7;
    localparam int AW = VW + DW;
    localparam int NB_DEPTH = MAX_VERTICES << DW;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EDGE, S_EDGE2,
        S_BFS_POP, S_BFS_V, S_BFS_CHK, S_BFS_NB,
        S_DFS_CHK, S_DFS_NB, S_DFS_POP
    } state_t;

    state_t                     state_reg;
    logic [gte_pkg::CMD_W-1:0]  cmd_reg;
    logic [gte_pkg::VTX_W-1:0]  a_reg;
    logic [gte_pkg::VTX_W-1:0]  b_reg;
    logic [gte_pkg::CNT_W-1:0]  vcount_reg;
    logic [DW-1:0]              deg_reg [MAX_VERTICES];
    logic [DW-1:0]              deg_a_reg;
    logic [MAX_VERTICES-1:0]    visited_reg;
    logic [VW-1:0]              cur_v_reg;
    logic [DW-1:0]              cur_pos_reg;
    logic [TW-1:0]              head_reg;
    logic [TW-1:0]              tail_reg;
    logic                       pend_valid_reg;
    logic [VW-1:0]              pend_reg;
    logic                       res_valid_reg;
    logic [gte_pkg::VTX_W-1:0]  res_vtx_reg;
    logic [gte_pkg::ST_W-1:0]   res_st_reg;
    logic                       res_last_reg;

    // memories
    logic [VW-1:0]      nb_mem [NB_DEPTH];
    logic [VW+DW-1:0]   fr_mem [MAX_VERTICES];
    logic [VW-1:0]      nb_rdata_reg;
    logic [VW+DW-1:0]   fr_rdata_reg;

    logic               nb_we;
    logic [AW-1:0]      nb_waddr;
    logic [VW-1:0]      nb_wdata;
    logic [AW-1:0]      nb_raddr;
    logic               fr_we;
    logic [VW-1:0]      fr_waddr;
    logic [VW+DW-1:0]   fr_wdata;
    logic [VW-1:0]      fr_raddr;

    logic [NW-1:0]      n_act;
    logic [VW-1:0]      a_idx;
    logic [VW-1:0]      b_idx;
    logic [VW-1:0]      deg_addr;
    logic [DW-1:0]      deg_rd;
    logic               edge_full;
    logic               nb_ok;
    logic [VW-1:0]      w_vtx;
    logic [TW-1:0]      tail_m1;
    logic [TW-1:0]      tail_m2;

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = res_valid_reg;
    assign visited_vertex = res_vtx_reg;
    assign status         = res_st_reg;
    assign last           = res_last_reg;

    // active vertex count, saturated
    always_comb
    begin
        if (NW'(vcount_reg) > NW'(MAX_VERTICES))
            n_act = NW'(MAX_VERTICES);
        else
            n_act = NW'(vcount_reg);
    end

    assign a_idx   = VW'(a_reg);
    assign b_idx   = VW'(b_reg);
    assign w_vtx   = nb_rdata_reg;
    assign tail_m1 = tail_reg - TW'(1);
    assign tail_m2 = tail_reg - TW'(2);
    assign nb_ok   = (NW'(w_vtx) < n_act) && !visited_reg[w_vtx]
                     && (tail_reg < TW'(MAX_VERTICES));

    // degree read port
    always_comb
    begin
        unique case (state_reg)
            S_DISPATCH:       deg_addr = a_idx;
            S_EDGE, S_EDGE2:  deg_addr = b_idx;
            default:          deg_addr = cur_v_reg;
        endcase
    end
    assign deg_rd = deg_reg[deg_addr];

    // list full check, second read of the degree is for the far end
    always_comb
    begin
        if (a_reg == b_reg)
            edge_full = ((DW+1)'(deg_a_reg) + (DW+1)'(2)) > (DW+1)'(MAX_DEGREE);
        else
            edge_full = (deg_a_reg >= DW'(MAX_DEGREE)) || (deg_rd >= DW'(MAX_DEGREE));
    end

    // memory port control
    always_comb
    begin
        nb_we    = 1'b0;
        nb_waddr = {a_idx, deg_a_reg};
        nb_wdata = b_idx;
        nb_raddr = {cur_v_reg, cur_pos_reg};
        fr_we    = 1'b0;
        fr_waddr = tail_reg[VW-1:0];
        fr_wdata = {w_vtx, {DW{1'b0}}};
        fr_raddr = head_reg[VW-1:0];
        unique case (state_reg)
            S_DISPATCH:
            begin
                fr_we    = 1'b1;
                fr_waddr = '0;
                fr_wdata = {a_idx, {DW{1'b0}}};
            end
            S_EDGE:
                nb_we = !edge_full;
            S_EDGE2:
            begin
                nb_we    = 1'b1;
                nb_waddr = {b_idx, deg_rd};
                nb_wdata = a_idx;
            end
            S_BFS_NB:
                fr_we = nb_ok;
            S_DFS_CHK:
                fr_raddr = tail_m2[VW-1:0];
            S_DFS_NB:
            begin
                fr_we    = nb_ok;
                fr_waddr = tail_m1[VW-1:0];
                fr_wdata = {cur_v_reg, cur_pos_reg};
            end
            default:
            begin
            end
        endcase
    end

    // neighbour memory
    always_ff @(posedge clk)
    begin
        if (nb_we)
            nb_mem[nb_waddr] <= nb_wdata;
        nb_rdata_reg <= nb_mem[nb_raddr];
    end

    // work list and frame memory
    always_ff @(posedge clk)
    begin
        if (fr_we)
            fr_mem[fr_waddr] <= fr_wdata;
        fr_rdata_reg <= fr_mem[fr_raddr];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= gte_pkg::CNT_W'(32);
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
                deg_reg[i] <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_wr_en)
                vcount_reg <= cfg_wr_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        a_reg     <= first_vertex;
                        b_reg     <= second_vertex;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    deg_a_reg   <= deg_rd;
                    res_vtx_reg <= '0;
                    res_last_reg <= 1'b1;
                    if (cmd_reg == gte_pkg::CMD_EDGE)
                    begin
                        if (NW'(a_reg) >= n_act || NW'(b_reg) >= n_act)
                        begin
                            res_valid_reg <= 1'b1;
                            res_st_reg    <= gte_pkg::ST_RANGE;
                            state_reg     <= S_IDLE;
                        end
                        else
                            state_reg <= S_EDGE;
                    end
                    else if (cmd_reg != gte_pkg::CMD_BFS && cmd_reg != gte_pkg::CMD_DFS)
                    begin
                        res_valid_reg <= 1'b1;
                        res_st_reg    <= gte_pkg::ST_RANGE;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        if (NW'(a_reg) >= n_act)
                        begin
                            visited_reg   <= '0;
                            res_valid_reg <= 1'b1;
                            res_st_reg    <= gte_pkg::ST_RANGE;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            // fresh marks with only the start vertex set
                            visited_reg <= MAX_VERTICES'(1) << a_idx;
                            head_reg    <= '0;
                            tail_reg    <= TW'(1);
                            cur_v_reg   <= a_idx;
                            cur_pos_reg <= '0;
                            if (cmd_reg == gte_pkg::CMD_BFS)
                            begin
                                pend_valid_reg <= 1'b0;
                                state_reg      <= S_BFS_POP;
                            end
                            else
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_reg       <= a_idx;
                                state_reg      <= S_DFS_CHK;
                            end
                        end
                    end
                end
                S_EDGE:
                begin
                    if (edge_full)
                    begin
                        res_valid_reg <= 1'b1;
                        res_st_reg    <= gte_pkg::ST_FULL;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        deg_reg[a_idx] <= deg_a_reg + DW'(1);
                        state_reg      <= S_EDGE2;
                    end
                end
                S_EDGE2:
                begin
                    deg_reg[b_idx] <= deg_rd + DW'(1);
                    res_valid_reg  <= 1'b1;
                    res_st_reg     <= gte_pkg::ST_OK;
                    state_reg      <= S_IDLE;
                end
                // breadth-first: take the next queued vertex
                S_BFS_POP:
                begin
                    if (head_reg < tail_reg)
                    begin
                        head_reg  <= head_reg + TW'(1);
                        state_reg <= S_BFS_V;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        res_vtx_reg   <= gte_pkg::VTX_W'(pend_reg);
                        res_st_reg    <= gte_pkg::ST_OK;
                        res_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_BFS_V:
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_vtx_reg   <= gte_pkg::VTX_W'(pend_reg);
                        res_st_reg    <= gte_pkg::ST_OK;
                        res_last_reg  <= 1'b0;
                    end
                    pend_valid_reg <= 1'b1;
                    pend_reg       <= fr_rdata_reg[VW+DW-1:DW];
                    cur_v_reg      <= fr_rdata_reg[VW+DW-1:DW];
                    cur_pos_reg    <= '0;
                    state_reg      <= S_BFS_CHK;
                end
                S_BFS_CHK:
                begin
                    if (cur_pos_reg < deg_rd)
                    begin
                        cur_pos_reg <= cur_pos_reg + DW'(1);
                        state_reg   <= S_BFS_NB;
                    end
                    else
                        state_reg <= S_BFS_POP;
                end
                S_BFS_NB:
                begin
                    if (nb_ok)
                    begin
                        visited_reg[w_vtx] <= 1'b1;
                        tail_reg           <= tail_reg + TW'(1);
                    end
                    state_reg <= S_BFS_CHK;
                end
                // depth-first: top frame lives in cur_v/cur_pos
                S_DFS_CHK:
                begin
                    if (cur_pos_reg < deg_rd)
                    begin
                        cur_pos_reg <= cur_pos_reg + DW'(1);
                        state_reg   <= S_DFS_NB;
                    end
                    else if (tail_reg == TW'(1))
                    begin
                        res_valid_reg <= 1'b1;
                        res_vtx_reg   <= gte_pkg::VTX_W'(pend_reg);
                        res_st_reg    <= gte_pkg::ST_OK;
                        res_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        tail_reg  <= tail_m1;
                        state_reg <= S_DFS_POP;
                    end
                end
                S_DFS_NB:
                begin
                    if (nb_ok)
                    begin
                        visited_reg[w_vtx] <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_vtx_reg   <= gte_pkg::VTX_W'(pend_reg);
                            res_st_reg    <= gte_pkg::ST_OK;
                            res_last_reg  <= 1'b0;
                        end
                        pend_reg    <= w_vtx;
                        cur_v_reg   <= w_vtx;
                        cur_pos_reg <= '0;
                        tail_reg    <= tail_reg + TW'(1);
                    end
                    state_reg <= S_DFS_CHK;
                end
                S_DFS_POP:
                begin
                    cur_v_reg   <= fr_rdata_reg[VW+DW-1:DW];
                    cur_pos_reg <= fr_rdata_reg[DW-1:0];
                    state_reg   <= S_DFS_CHK;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/gte_checker.sv]
// ----------------------------------------------------------------------------
// gte_checker
// Port-level checks for the graph traversal engine, bound to the top level.
// ----------------------------------------------------------------------------
module gte_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        result_valid,
    input  logic [gte_pkg::VTX_W-1:0]   visited_vertex,
    input  logic [gte_pkg::ST_W-1:0]    status,
    input  logic                        last
);

    // an accepted transaction always occupies the engine
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("engine not busy after accepted transaction");

    // error results end their transaction
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != gte_pkg::ST_OK |-> last)
        else $error("error result without last");

    // error results carry no vertex
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != gte_pkg::ST_OK |-> visited_vertex == '0)
        else $error("error result with nonzero vertex");

    // a non-final result means traversal is still running
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

endmodule

bind graph_traversal_engine_top gte_checker u_gte_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_valid   (result_valid),
    .visited_vertex (visited_vertex),
    .status         (status),
    .last           (last)
);
